FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked on the rising edge, off while in reset.
`define TMCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define TMCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/tmcr_pkg.sv
package tmcr_pkg;

    // Fixed-point position format
    localparam int POS_W  = 24;
    localparam int FRAC_W = 8;

    // Geometry, whole pixels
    localparam int TILE_SIZE     = 64;
    localparam int AGENT_SIZE    = 60;
    localparam int AGENT_HALF    = 30;
    localparam int PUSH_DISTANCE = 62;

    localparam int MAP_COLS_DEF = 64;
    localparam int MAP_ROWS_DEF = 64;

    localparam int TILE_IDX_IN_W = 6;
    localparam int CFG_W         = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_W-1:0] MAP_DIM_RESET = CFG_W'(64);

    // Derived widths: tile size is a power of two, so the tile index is a bit slice
    localparam int TILE_SHIFT = $clog2(TILE_SIZE) + FRAC_W;
    localparam int CRD_W      = POS_W + 1;
    localparam int TIDX_W     = CRD_W - TILE_SHIFT;
    localparam int TU_W       = TIDX_W - 1;
    localparam int DX_W       = POS_W + 2;
    localparam int DEP_W      = DX_W + 1;
    localparam int SUM_W      = DEP_W + 1;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                     opcode;
        logic [TILE_IDX_IN_W-1:0] tile_col;
        logic [TILE_IDX_IN_W-1:0] tile_row;
        logic                     tile_solid;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] new_pos_x;
        logic signed [POS_W-1:0] new_pos_y;
        logic                    collided;
    } t_out_word;

    typedef struct packed {
        logic       clear;
        logic       tile_wr;
        logic       load;
        logic       read;
        logic       check;
        logic       apply;
        logic       out_load;
        logic [1:0] corner;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic solid;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/tmcr_ctrl.sv
`include "assert_macros.svh"

module tmcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_opcode,
    input  tmcr_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output tmcr_pkg::t_dp_cmd  o_cmd
);
    import tmcr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_APPLY,
        ST_OUT
    } t_state;

    localparam logic [1:0] K_LAST = 2'd3;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       accept;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        o_cmd        = '0;
        o_cmd.corner = r_k;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_RESOLVE) begin
                        o_cmd.load = 1'b1;
                        n_k        = '0;
                        n_state    = ST_READ;
                    end else begin
                        o_cmd.tile_wr = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.solid) begin
                    n_state = ST_APPLY;
                end else if (r_k == K_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_k     = 2'(r_k + 2'd1);
                    n_state = ST_READ;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                if (r_k == K_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_k     = 2'(r_k + 2'd1);
                    n_state = ST_READ;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    `TMCR_ASSERT_NEXT(a_load_then_busy, i_clk, i_rst_n, o_cmd.load, o_in_stall)
    `TMCR_ASSERT_IMP(a_apply_after_check, i_clk, i_rst_n, r_state == ST_APPLY, $past(r_state) == ST_CHECK)
    `TMCR_ASSERT_IMP(a_out_after_last, i_clk, i_rst_n, r_state == ST_OUT, r_k == K_LAST)

endmodule

FILE: rtl/tmcr_datapath.sv
`include "assert_macros.svh"

module tmcr_datapath #(
    parameter int MAP_COLS = tmcr_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = tmcr_pkg::MAP_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tmcr_pkg::t_dp_cmd              i_cmd,
    output tmcr_pkg::t_dp_stat             o_stat,
    input  tmcr_pkg::t_in_word             i_in_word,
    output tmcr_pkg::t_out_word            o_out_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic [tmcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import tmcr_pkg::*;

    localparam int DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [ADDR_W-1:0]       LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [TIDX_W-1:0]       COLS_LIM   = TIDX_W'(MAP_COLS);
    localparam logic [TIDX_W-1:0]       ROWS_LIM   = TIDX_W'(MAP_ROWS);
    localparam logic signed [CRD_W-1:0] AGENT_SPAN = CRD_W'(AGENT_SIZE * (2 ** FRAC_W));
    localparam logic [DX_W-1:0]         HALF_TILE  = DX_W'(TILE_SIZE * (2 ** (FRAC_W - 1)));
    localparam logic signed [DX_W-1:0]  HALF_AGENT = DX_W'(AGENT_HALF * (2 ** FRAC_W));
    localparam logic signed [DEP_W-1:0] REACH      = DEP_W'(PUSH_DISTANCE * (2 ** FRAC_W));
    localparam logic signed [SUM_W-1:0] POS_MAX    = SUM_W'((2 ** (POS_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] POS_MIN    = SUM_W'(-(2 ** (POS_W - 1)));

    // configuration
    logic [CFG_W-1:0] r_map_w, r_map_h;

    // tile store and its ports
    logic              r_tile_mem [DEPTH];
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en, wr_data, wr_in_range;
    logic              r_rd_solid;

    // position state
    logic signed [POS_W-1:0] r_x0, r_y0, r_px, r_py;
    logic                    r_hit;

    // corner lookup
    logic signed [CRD_W-1:0] crn_x, crn_y;
    logic [TIDX_W-1:0]       crn_col, crn_row;
    logic                    crn_in_map;
    logic [TU_W-1:0]         r_col, r_row;
    logic                    r_in_map;

    // push depths
    logic [DX_W-1:0]          ctr_x, ctr_y;
    logic signed [DX_W-1:0]   dx, dy;
    logic [DX_W-1:0]          adx, ady;
    logic signed [DEP_W-1:0]  xd, yd;
    logic signed [DEP_W-1:0]  r_xd, r_yd;
    logic                     r_dx_neg, r_dy_neg;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [POS_W-1:0]  sat_x, sat_y;
    logic                     do_push, push_x;

    // output register
    tmcr_pkg::t_out_word r_out;
    logic                r_out_valid;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= MAP_DIM_RESET;
            r_map_h <= MAP_DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAP_WIDTH) begin
                r_map_w <= i_cfg_data;
            end
            if (i_cfg_index == CFG_MAP_HEIGHT) begin
                r_map_h <= i_cfg_data;
            end
        end
    end

    // ---- tile store ----
    assign wr_in_range = (TIDX_W'(i_in_word.tile_col) < COLS_LIM)
                      && (TIDX_W'(i_in_word.tile_row) < ROWS_LIM);

    always_comb begin
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 1'b0;
        end else begin
            wr_en   = i_cmd.tile_wr && wr_in_range;
            wr_addr = ADDR_W'(32'(i_in_word.tile_row) * MAP_COLS
                            + 32'(i_in_word.tile_col));
            wr_data = i_in_word.tile_solid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tile_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read) begin
            r_rd_solid <= r_tile_mem[rd_addr];
        end
    end

    // ---- corner of the original position, floor by tile span is a bit slice ----
    assign crn_x   = i_cmd.corner[0] ? CRD_W'(r_x0) + AGENT_SPAN : CRD_W'(r_x0);
    assign crn_y   = i_cmd.corner[1] ? CRD_W'(r_y0) + AGENT_SPAN : CRD_W'(r_y0);
    assign crn_col = crn_x[CRD_W-1:TILE_SHIFT];
    assign crn_row = crn_y[CRD_W-1:TILE_SHIFT];

    assign crn_in_map = !crn_col[TIDX_W-1] && !crn_row[TIDX_W-1]
                     && (crn_col < COLS_LIM) && (crn_col < TIDX_W'(r_map_w))
                     && (crn_row < ROWS_LIM) && (crn_row < TIDX_W'(r_map_h));

    assign rd_addr = ADDR_W'(32'(crn_row[TU_W-1:0]) * MAP_COLS + 32'(crn_col[TU_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_col    <= crn_col[TU_W-1:0];
            r_row    <= crn_row[TU_W-1:0];
            r_in_map <= crn_in_map;
        end
    end

    // ---- overlap depths against the tile centre ----
    assign ctr_x = DX_W'({r_col, {TILE_SHIFT{1'b0}}}) + HALF_TILE;
    assign ctr_y = DX_W'({r_row, {TILE_SHIFT{1'b0}}}) + HALF_TILE;
    assign dx    = DX_W'(r_px) + HALF_AGENT - $signed(ctr_x);
    assign dy    = DX_W'(r_py) + HALF_AGENT - $signed(ctr_y);
    assign adx   = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    assign ady   = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
    assign xd    = REACH - $signed({1'b0, adx});
    assign yd    = REACH - $signed({1'b0, ady});

    // ---- push step ----
    assign do_push = (r_xd > 0) && (r_yd > 0);
    assign push_x  = (r_xd < r_yd);
    assign sum_x   = r_dx_neg ? SUM_W'(r_px) - SUM_W'(r_xd) : SUM_W'(r_px) + SUM_W'(r_xd);
    assign sum_y   = r_dy_neg ? SUM_W'(r_py) - SUM_W'(r_yd) : SUM_W'(r_py) + SUM_W'(r_yd);

    always_comb begin
        if (sum_x > POS_MAX) begin
            sat_x = POS_W'(POS_MAX);
        end else if (sum_x < POS_MIN) begin
            sat_x = POS_W'(POS_MIN);
        end else begin
            sat_x = POS_W'(sum_x);
        end
        if (sum_y > POS_MAX) begin
            sat_y = POS_W'(POS_MAX);
        end else if (sum_y < POS_MIN) begin
            sat_y = POS_W'(POS_MIN);
        end else begin
            sat_y = POS_W'(sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_in_word.pos_x;
            r_y0 <= i_in_word.pos_y;
            r_px <= i_in_word.pos_x;
            r_py <= i_in_word.pos_y;
        end else if (i_cmd.apply && do_push) begin
            if (push_x) begin
                r_px <= sat_x;
            end else begin
                r_py <= sat_y;
            end
        end
        if (i_cmd.check) begin
            r_xd     <= xd;
            r_yd     <= yd;
            r_dx_neg <= dx[DX_W-1];
            r_dy_neg <= dy[DX_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.check && o_stat.solid) begin
            r_hit <= 1'b1;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.new_pos_x <= r_px;
            r_out.new_pos_y <= r_py;
            r_out.collided  <= r_hit;
        end
    end

    assign o_out_word        = r_out;
    assign o_out_valid       = r_out_valid;
    assign o_stat.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_stat.solid      = r_in_map && r_rd_solid;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    `TMCR_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, i_cmd.out_load, o_out_valid)
    `TMCR_ASSERT_IMP(a_clear_exclusive, i_clk, i_rst_n, i_cmd.clear, !i_cmd.tile_wr && !i_cmd.load && !i_cmd.read)
    `TMCR_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

endmodule

FILE: rtl/tile_map_collision_resolver_core.sv
// Tile map collision resolver.
// Input channel (i_in_valid / o_in_stall, word i_in_word): a write word
// (opcode write) sets one tile solid or air and is done in the cycle it is
// accepted. A resolve word gives the agent's top-left corner; the block looks
// up the tiles under the four corners and pushes the agent out of each solid
// one, then returns the position and a collision flag on the output channel
// (o_out_valid / i_out_stall, word o_out_word). A write word gives no result.
// The sequencer sets the cost of a resolve: a tile store read and a depth
// check per corner, plus a push step for each solid corner, then a load of
// the output register. One resolve is in flight at a time and the next word
// is taken the cycle after the result is loaded.
// A result waits in the output register while i_out_stall is high; the block
// still accepts write words and starts the next resolve meanwhile, holding
// that one only until the register frees.
// Reset sets both map dimensions to 64 and then clears the tile store to air,
// one tile a cycle, with o_in_stall high. Configuration writes (o_cfg_ready
// is always high) are taken at any time, clearing included, but should only
// change between items.
module tile_map_collision_resolver_core #(
    parameter int MAP_COLS = tmcr_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = tmcr_pkg::MAP_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tmcr_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tmcr_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tmcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmcr_pkg::CFG_W-1:0]     i_cfg_data
);
    import tmcr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tmcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_word.opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tmcr_datapath #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: tb/tile_map_collision_resolver_core_tb.sv
`timescale 1ns / 1ps

module tile_map_collision_resolver_core_tb;

    import tmcr_pkg::*;

    localparam int     WATCHDOG_LIMIT = 12000;  // covers the tile store clear after reset
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     PHASE_WORDS    = 275;
    localparam int     N_TILES        = MAP_COLS_DEF * MAP_ROWS_DEF;
    localparam longint TILE_FX        = longint'(TILE_SIZE) << FRAC_W;
    localparam longint POS_TOP        = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_BOTTOM     = -(longint'(1) << (POS_W - 1));

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;

    wire in_acc  = i_in_valid && !o_in_stall;
    wire out_acc = o_out_valid && !i_out_stall;
    wire cfg_acc = i_cfg_valid && o_cfg_ready;

    tile_map_collision_resolver_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the block's state
    bit               solid_tiles [N_TILES];
    logic [CFG_W-1:0] cols_in_use = MAP_DIM_RESET;
    logic [CFG_W-1:0] rows_in_use = MAP_DIM_RESET;
    t_out_word        pending_positions [$];

    int fails       = 0;
    int words_sent  = 0;
    int results     = 0;
    int collisions  = 0;
    int cfg_writes  = 0;
    int idle_cycles = 0;
    int stall_hold  = 0;
    bit quiet       = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint fx(input longint pixels);
        return pixels << FRAC_W;
    endfunction

    function automatic longint saturate_pos(input longint v);
        if (v > POS_TOP) return POS_TOP;
        if (v < POS_BOTTOM) return POS_BOTTOM;
        return v;
    endfunction

    // store index of the tile under a point, -1 when off the map in use
    function automatic longint tile_at(input longint px, input longint py);
        longint col, row, w, h;
        col = px >>> TILE_SHIFT;
        row = py >>> TILE_SHIFT;
        w = (cols_in_use > MAP_COLS_DEF) ? MAP_COLS_DEF : cols_in_use;
        h = (rows_in_use > MAP_ROWS_DEF) ? MAP_ROWS_DEF : rows_in_use;
        if (col < 0 || col >= w || row < 0 || row >= h) return -1;
        return row * MAP_COLS_DEF + col;
    endfunction

    function automatic t_out_word resolved_position(input logic signed [POS_W-1:0] ax,
                                                    input logic signed [POS_W-1:0] ay);
        longint    x, y, side, reach, cx, cy, dx, dy, xd, yd;
        longint    under [4];
        t_out_word res;
        x = ax;
        y = ay;
        side = longint'(AGENT_SIZE) << FRAC_W;
        reach = longint'(PUSH_DISTANCE) << FRAC_W;
        // corner tiles come from the original position
        under[0] = tile_at(x, y);
        under[1] = tile_at(x + side, y);
        under[2] = tile_at(x, y + side);
        under[3] = tile_at(x + side, y + side);
        res = '0;
        foreach (under[k]) begin
            if (under[k] >= 0 && solid_tiles[int'(under[k])]) begin
                res.collided = 1'b1;
                cx = (under[k] % MAP_COLS_DEF) * TILE_FX + TILE_FX / 2;
                cy = (under[k] / MAP_COLS_DEF) * TILE_FX + TILE_FX / 2;
                dx = x + (longint'(AGENT_HALF) << FRAC_W) - cx;
                dy = y + (longint'(AGENT_HALF) << FRAC_W) - cy;
                xd = reach - (dx < 0 ? -dx : dx);
                yd = reach - (dy < 0 ? -dy : dy);
                // each push sees the position left by the last one
                if (xd > 0 && yd > 0) begin
                    if (xd < yd) begin
                        x = saturate_pos(dx < 0 ? x - xd : x + xd);
                    end else begin
                        y = saturate_pos(dy < 0 ? y - yd : y + yd);
                    end
                end
            end
        end
        res.new_pos_x = x[POS_W-1:0];
        res.new_pos_y = y[POS_W-1:0];
        return res;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w.opcode     = 1'($urandom);
        w.tile_col   = TILE_IDX_IN_W'($urandom);
        w.tile_row   = TILE_IDX_IN_W'($urandom);
        w.tile_solid = 1'($urandom);
        w.pos_x      = POS_W'($urandom);
        w.pos_y      = POS_W'($urandom);
        return w;
    endfunction

    // scoreboard: results first, then the word taken at the same edge
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            foreach (solid_tiles[i]) solid_tiles[i] = 1'b0;
            cols_in_use = MAP_DIM_RESET;
            rows_in_use = MAP_DIM_RESET;
        end else begin
            if (out_acc) begin
                if (pending_positions.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    want = pending_positions.pop_front();
                    results++;
                    if (want.collided) collisions++;
                    if (o_out_word.new_pos_x !== want.new_pos_x) begin
                        $error("new_pos_x: expected %0d, got %0d",
                               want.new_pos_x, o_out_word.new_pos_x);
                        fails++;
                    end
                    if (o_out_word.new_pos_y !== want.new_pos_y) begin
                        $error("new_pos_y: expected %0d, got %0d",
                               want.new_pos_y, o_out_word.new_pos_y);
                        fails++;
                    end
                    if (o_out_word.collided !== want.collided) begin
                        $error("collided: expected %0d, got %0d",
                               want.collided, o_out_word.collided);
                        fails++;
                    end
                end
            end
            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_MAP_WIDTH:  cols_in_use = i_cfg_data;
                    CFG_MAP_HEIGHT: rows_in_use = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (i_in_word.opcode == OP_WRITE) begin
                    solid_tiles[{i_in_word.tile_row, i_in_word.tile_col}] = i_in_word.tile_solid;
                end else begin
                    pending_positions.insert(pending_positions.size(),
                                             resolved_position(i_in_word.pos_x,
                                                               i_in_word.pos_y));
                end
            end
        end
    end

    // output back-pressure: held for random stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 2) == 0);
            stall_hold  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (in_acc || out_acc || cfg_acc) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!in_acc) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic put_tile(input int col, input int row, input bit solid);
        t_in_word w;
        w            = rand_word();
        w.opcode     = OP_WRITE;
        w.tile_col   = TILE_IDX_IN_W'(col);
        w.tile_row   = TILE_IDX_IN_W'(row);
        w.tile_solid = solid;
        send_word(w);
    endtask

    task automatic put_agent(input longint x, input longint y);
        t_in_word w;
        w        = rand_word();
        w.opcode = OP_RESOLVE;
        w.pos_x  = x[POS_W-1:0];
        w.pos_y  = y[POS_W-1:0];
        send_word(w);
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_acc) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic test_empty_map();
        put_agent(POS_TOP, POS_TOP);
        put_agent(POS_BOTTOM, POS_BOTTOM);
        put_agent(0, 0);
        put_agent(-1, -1);
    endtask

    task automatic test_push_directions();
        put_tile(3, 3, 1'b1);
        put_agent(fx(194), fx(194));              // one tile under all four corners
        put_agent(fx(140) + 8'h80, fx(200));      // from the left
        put_agent(fx(250), fx(200) + 8'h3c);      // from the right
        put_agent(fx(200) + 8'hff, fx(140));      // from above
        put_agent(fx(200), fx(250) + 8'h01);      // from below
        put_tile(0, 0, 1'b1);
        put_tile(63, 63, 1'b1);
        put_agent(fx(-10), fx(-10));              // three corners off the map
        put_agent(fx(4060), fx(4060));            // bottom-right edge
        put_tile(3, 3, 1'b0);
        put_agent(fx(194), fx(194));
    endtask

    task automatic test_map_limits();
        put_tile(3, 3, 1'b1);
        drain_results();
        write_reg(CFG_MAP_WIDTH, CFG_W'(3));      // column 3 drops out
        put_agent(fx(194), fx(194));
        put_agent(fx(-10), fx(-10));
        drain_results();
        write_reg(CFG_MAP_WIDTH, CFG_W'(127));
        write_reg(CFG_MAP_HEIGHT, '0);            // no rows at all
        put_agent(fx(-10), fx(-10));
        drain_results();
        write_reg(CFG_MAP_HEIGHT, CFG_W'(127));   // both clamped to the store
        put_agent(fx(4060), fx(4060));
        drain_results();
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_W'($urandom));
        put_agent(fx(194), fx(194));
        put_agent(fx(4000), fx(4030));
        drain_results();
        write_reg(CFG_MAP_WIDTH, MAP_DIM_RESET);
        write_reg(CFG_MAP_HEIGHT, MAP_DIM_RESET);
    endtask

    task automatic run_scene();
        int     kind, n, c, r, w, h;
        longint bx, by;
        kind  = $urandom_range(0, 99);
        quiet = ($urandom_range(0, 11) == 0);
        w = (cols_in_use == 0) ? 1 : (cols_in_use > MAP_COLS_DEF ? MAP_COLS_DEF : cols_in_use);
        h = (rows_in_use == 0) ? 1 : (rows_in_use > MAP_ROWS_DEF ? MAP_ROWS_DEF : rows_in_use);
        if (kind < 65) begin
            // a 2x2 patch of tiles, then agents dropped around its centre
            c = $urandom_range(0, w - 1);
            r = $urandom_range(0, h - 1);
            n = $urandom_range(1, 4);
            repeat (n) put_tile(c + $urandom_range(0, 1), r + $urandom_range(0, 1),
                                $urandom_range(0, 3) != 0);
            n = $urandom_range(1, 4);
            repeat (n) begin
                bx = longint'(c) * TILE_FX - TILE_FX / 2 + $urandom_range(0, 2 * TILE_FX);
                by = longint'(r) * TILE_FX - TILE_FX / 2 + $urandom_range(0, 2 * TILE_FX);
                put_agent(bx, by);
            end
        end else if (kind < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                bx = longint'($urandom_range(0, (w + 2) * TILE_FX)) - TILE_FX;
                by = longint'($urandom_range(0, (h + 2) * TILE_FX)) - TILE_FX;
                put_agent(bx, by);
            end
        end else if (kind < 90) begin
            n = $urandom_range(1, 6);
            repeat (n) put_tile($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(rand_word());
        end
    endtask

    task automatic test_random_scenes();
        int target;
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(CFG_MAP_WIDTH, CFG_W'(64));
                    write_reg(CFG_MAP_HEIGHT, CFG_W'(64));
                end
                1: begin
                    write_reg(CFG_MAP_WIDTH, CFG_W'(127));
                    write_reg(CFG_MAP_HEIGHT, CFG_W'(127));
                end
                2: begin
                    write_reg(CFG_MAP_WIDTH, CFG_W'(1));
                    write_reg(CFG_MAP_HEIGHT, CFG_W'(1));
                end
                3: begin
                    write_reg(CFG_MAP_WIDTH, CFG_W'($urandom_range(1, 127)));
                    write_reg(CFG_MAP_HEIGHT, CFG_W'($urandom_range(1, 127)));
                end
                4: begin
                    write_reg(CFG_MAP_WIDTH, CFG_W'($urandom_range(0, 127)));
                    write_reg(CFG_MAP_HEIGHT, CFG_W'($urandom_range(0, 127)));
                end
                default: begin
                    write_reg(CFG_MAP_WIDTH, MAP_DIM_RESET);
                    write_reg(CFG_MAP_HEIGHT, MAP_DIM_RESET);
                end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) run_scene();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_map();
        test_push_directions();
        test_map_limits();
        test_random_scenes();
        drain_results();

        if (pending_positions.size() != 0) begin
            $error("%0d results never arrived", pending_positions.size());
            fails++;
        end
        $display("Sent %0d words; checked %0d positions, %0d of them with a collision",
                 words_sent, results, collisions);
        $display("Map sizes from empty to clamped, %0d register writes, random gaps and stalls",
                 cfg_writes);
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tmcr_pkg.sv
rtl/tmcr_ctrl.sv
rtl/tmcr_datapath.sv
rtl/tile_map_collision_resolver_core.sv
tb/tile_map_collision_resolver_core_tb.sv
